@@ sv/sbic_pkg.sv @@
// shared types and constants for the split bank instruction cache
package sbic_pkg;

  localparam int ADDR_BITS      = 32;
  localparam int LINE_OFS_BITS  = 5;
  localparam int LINE_BITS      = ADDR_BITS - LINE_OFS_BITS;
  localparam int WORD_BITS      = LINE_OFS_BITS - 3;
  localparam int FILL_BITS      = 64;
  localparam int FETCH_BITS     = 32;
  localparam int HALF_BITS      = 16;

  localparam logic [LINE_OFS_BITS-1:0] OFS_LAST  = 5'h1E;
  localparam logic [LINE_OFS_BITS-1:0] OFS_STEP  = 5'h02;
  localparam logic [WORD_BITS-1:0]     WORD_LAST = '1;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_REQ  = 2'd1;
  localparam logic [1:0] KIND_REJ  = 2'd2;

  typedef struct packed {
    logic                  func;
    logic [ADDR_BITS-1:0]  fetch_address;
    logic [FILL_BITS-1:0]  fill_data;
  } in_t;

  typedef struct packed {
    logic [1:0]            kind;
    logic [FETCH_BITS-1:0] fetch_data;
    logic [LINE_BITS-1:0]  request_line;
    logic                  last;
  } out_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLR,
    OP_TAG0,
    OP_TAG1,
    OP_CHK,
    OP_DAT0,
    OP_DAT1,
    OP_DAT2,
    OP_PEND,
    OP_FRD,
    OP_FWR,
    OP_LOADPF
  } op_t;

  typedef enum logic [1:0] {
    SEL_REJ,
    SEL_DATA,
    SEL_REQ0,
    SEL_REQ1
  } out_sel_t;

  typedef struct packed {
    op_t      op;
    logic     accept;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic is_fill;
    logic pending;
    logic miss;
    logic two_pend;
    logic last_word;
    logic last_line;
    logic out_free;
  } dp_stat_t;

endpackage

@@ sv/split_bank_instruction_cache_top.sv @@
// top level of the split bank instruction cache
//
//  port group | dir | payload  | transfer when
//  in_        | in  | in_t     | in_valid & !in_stall
//  out_       | out | out_t    | out_valid & !out_stall
//
// hit fetch: serial tag and line reads lie between transfer and result
// fill word: one order/tag read then the line write
// miss: one refill request per missing line
// after reset a clearing pass over all 2**(SET_BITS+1) tag rows holds in_stall high
// a stalled result holds the controller; results leave through one output register
module split_bank_instruction_cache_top import sbic_pkg::*; #(
  parameter int WAYS     = 4,
  parameter int SET_BITS = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sbic_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .stat(stat), .cmd(cmd)
  );

  sbic_dp #(.WAYS(WAYS), .SET_BITS(SET_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .out_stall(out_stall),
    .out_data(out_data), .out_valid(out_valid), .cmd(cmd), .stat(stat)
  );

endmodule

@@ sv/sbic_ram.sv @@
// generic single write port ram with registered read
module sbic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/sbic_dp.sv @@
// cache datapath: tag, order and line memories, pending state, result register
module sbic_dp import sbic_pkg::*; #(
  parameter int WAYS     = 4,
  parameter int SET_BITS = 8
) (
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  logic     out_stall,
  output out_t     out_data,
  output logic     out_valid,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat
);

  localparam int WB    = $clog2(WAYS);
  localparam int TAGW  = LINE_BITS - 1 - SET_BITS;
  localparam int ENTW  = TAGW + 1;
  localparam int ROWB  = SET_BITS + 1;
  localparam int ROWS  = 1 << ROWB;
  localparam int DAB   = ROWB + WB + WORD_BITS;
  localparam int DWRDS = 1 << DAB;

  in_t                    in_r;
  logic [ADDR_BITS-1:0]   la_r, pf_r;
  logic [LINE_BITS-1:0]   pl0_r, pl1_r;
  logic [1:0]             pcnt_r;
  logic [WORD_BITS-1:0]   fwi_r;
  logic                   hit0_r, hit1_r;
  logic [WB-1:0]          w0_r, w1_r;
  logic [HALF_BITS-1:0]   lo_r;
  logic [FETCH_BITS-1:0]  dat_r;
  logic [ROWB-1:0]        clr_r;
  out_t                   out_r;
  logic                   out_valid_r;

  logic [LINE_BITS-1:0]     ln0, ln1;
  logic [LINE_OFS_BITS-1:0] off, off1;
  logic                     ov;
  logic [TAGW-1:0]          mtag;
  logic                     mhit;
  logic [WB-1:0]            mway, vic;
  logic [HALF_BITS-1:0]     half0, half1;

  logic                   tag_we, ord_we;
  logic [ROWB-1:0]        tag_wa, tag_ra, plrow;
  logic [WAYS*ENTW-1:0]   tag_wd, tag_rd, tag_upd;
  logic [WAYS*WB-1:0]     ord_wd, ord_rd, ord_init, ord_rot;
  logic [DAB-1:0]         dat_ra, dat_wa;
  logic [FILL_BITS-1:0]   dat_rd;

  assign ln0   = la_r[ADDR_BITS-1:LINE_OFS_BITS];
  assign off   = {la_r[LINE_OFS_BITS-1:1], 1'b0};
  assign ov    = (off == OFS_LAST);
  assign ln1   = ov ? ln0 + LINE_BITS'(1) : ln0;
  assign off1  = ov ? '0 : off + OFS_STEP;
  assign mtag  = (cmd.op == OP_TAG1) ? ln0[LINE_BITS-1:ROWB] : ln1[LINE_BITS-1:ROWB];
  assign plrow = pl0_r[ROWB-1:0];
  assign vic   = ord_rd[WB-1:0];
  assign half0 = HALF_BITS'(dat_rd >> {off[2:1], 4'd0});
  assign half1 = HALF_BITS'(dat_rd >> {off1[2:1], 4'd0});

  always_comb begin
    mhit = 1'b0;
    mway = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (tag_rd[w*ENTW +: ENTW] == {1'b1, mtag}) begin
        mhit = 1'b1;
        mway = WB'(w);
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      ord_init[w*WB +: WB] = WB'(w);
      tag_upd[w*ENTW +: ENTW] = (WB'(w) == vic) ? {1'b1, pl0_r[LINE_BITS-1:ROWB]}
                                               : tag_rd[w*ENTW +: ENTW];
    end
    for (int k = 0; k < WAYS - 1; k++) begin
      ord_rot[k*WB +: WB] = ord_rd[(k+1)*WB +: WB];
    end
    ord_rot[(WAYS-1)*WB +: WB] = vic;
  end

  always_comb begin
    priority case (cmd.op)
      OP_FRD:  tag_ra = plrow;
      OP_TAG1: tag_ra = ln1[ROWB-1:0];
      default: tag_ra = ln0[ROWB-1:0];
    endcase
  end

  assign tag_we = (cmd.op == OP_CLR) || (cmd.op == OP_FWR && fwi_r == WORD_LAST);
  assign ord_we = tag_we;
  assign tag_wa = (cmd.op == OP_CLR) ? clr_r : plrow;
  assign tag_wd = (cmd.op == OP_CLR) ? '0 : tag_upd;
  assign ord_wd = (cmd.op == OP_CLR) ? ord_init : ord_rot;
  assign dat_ra = (cmd.op == OP_DAT0) ? {ln0[ROWB-1:0], w0_r, off[LINE_OFS_BITS-1:3]}
                                      : {ln1[ROWB-1:0], w1_r, off1[LINE_OFS_BITS-1:3]};
  assign dat_wa = {plrow, vic, fwi_r};

  sbic_ram #(.WIDTH(WAYS*ENTW), .DEPTH(ROWS)) u_tag (
    .clk(clk), .we(tag_we), .waddr(tag_wa), .wdata(tag_wd),
    .raddr(tag_ra), .rdata(tag_rd)
  );

  sbic_ram #(.WIDTH(WAYS*WB), .DEPTH(ROWS)) u_ord (
    .clk(clk), .we(ord_we), .waddr(tag_wa), .wdata(ord_wd),
    .raddr(plrow), .rdata(ord_rd)
  );

  sbic_ram #(.WIDTH(FILL_BITS), .DEPTH(DWRDS)) u_line (
    .clk(clk), .we(cmd.op == OP_FWR), .waddr(dat_wa), .wdata(in_r.fill_data),
    .raddr(dat_ra), .rdata(dat_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pf_r        <= '0;
      pl0_r       <= '0;
      pl1_r       <= '0;
      pcnt_r      <= '0;
      fwi_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_CLR: clr_r <= clr_r + ROWB'(1);
        OP_PEND: begin
          pf_r  <= la_r;
          fwi_r <= '0;
          if (!hit0_r) begin
            pl0_r  <= ln0;
            pl1_r  <= (ov && !hit1_r) ? ln1 : '0;
            pcnt_r <= (ov && !hit1_r) ? 2'd2 : 2'd1;
          end else begin
            pl0_r  <= ln1;
            pl1_r  <= '0;
            pcnt_r <= 2'd1;
          end
        end
        OP_FWR: begin
          if (fwi_r == WORD_LAST) begin
            fwi_r  <= '0;
            pl0_r  <= pl1_r;
            pl1_r  <= '0;
            pcnt_r <= pcnt_r - 2'd1;
          end else begin
            fwi_r <= fwi_r + WORD_BITS'(1);
          end
        end
        default: ;
      endcase
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_r <= in_data;
      la_r <= in_data.fetch_address;
    end else if (cmd.op == OP_LOADPF) begin
      la_r <= pf_r;
    end
    if (cmd.op == OP_TAG1) begin
      hit0_r <= mhit;
      w0_r   <= mway;
    end
    if (cmd.op == OP_CHK) begin
      hit1_r <= mhit;
      w1_r   <= mway;
    end
    if (cmd.op == OP_DAT1) begin
      lo_r <= half0;
    end
    if (cmd.op == OP_DAT2) begin
      dat_r <= {half1, lo_r};
    end
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        SEL_REJ:  out_r <= '{kind: KIND_REJ, fetch_data: '0, request_line: '0, last: 1'b1};
        SEL_DATA: out_r <= '{kind: KIND_DATA, fetch_data: dat_r, request_line: '0,
                             last: 1'b1};
        SEL_REQ0: out_r <= '{kind: KIND_REQ, fetch_data: '0, request_line: pl0_r,
                             last: (pcnt_r == 2'd1)};
        SEL_REQ1: out_r <= '{kind: KIND_REQ, fetch_data: '0, request_line: pl1_r,
                             last: 1'b1};
      endcase
    end
  end

  assign out_data = out_r;
  assign out_valid = out_valid_r;

  assign stat.clr_last  = &clr_r;
  assign stat.is_fill   = in_r.func;
  assign stat.pending   = (pcnt_r != 2'd0);
  assign stat.miss      = !hit0_r || (ov && !hit1_r);
  assign stat.two_pend  = (pcnt_r == 2'd2);
  assign stat.last_word = (fwi_r == WORD_LAST);
  assign stat.last_line = (pcnt_r == 2'd1);
  assign stat.out_free  = !out_valid_r || !out_stall;

endmodule

@@ sv/sbic_ctrl.sv @@
// cache controller state machine
module sbic_ctrl import sbic_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DEC, S_T0, S_T1, S_CHK, S_EV, S_D1, S_D2,
    S_ODATA, S_REQ0, S_REQ1, S_REJ, S_FWR, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   fin_r, fin_nxt;

  always_comb begin
    state_nxt    = state_r;
    fin_nxt      = fin_r;
    cmd.op       = OP_NONE;
    cmd.accept   = 1'b0;
    cmd.out_load = 1'b0;
    cmd.out_sel  = SEL_REJ;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          fin_nxt    = 1'b0;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.is_fill) begin
          if (stat.pending) begin
            cmd.op    = OP_FRD;
            state_nxt = S_FWR;
          end else begin
            state_nxt = S_REJ;
          end
        end else if (stat.pending) begin
          state_nxt = S_REJ;
        end else begin
          state_nxt = S_T0;
        end
      end
      S_T0: begin
        cmd.op    = OP_TAG0;
        state_nxt = S_T1;
      end
      S_T1: begin
        cmd.op    = OP_TAG1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        cmd.op    = OP_CHK;
        state_nxt = S_EV;
      end
      S_EV: begin
        if (fin_r || !stat.miss) begin
          cmd.op    = OP_DAT0;
          state_nxt = S_D1;
        end else begin
          cmd.op    = OP_PEND;
          state_nxt = S_REQ0;
        end
      end
      S_D1: begin
        cmd.op    = OP_DAT1;
        state_nxt = S_D2;
      end
      S_D2: begin
        cmd.op    = OP_DAT2;
        state_nxt = S_ODATA;
      end
      S_ODATA: begin
        cmd.out_sel = SEL_DATA;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_REQ0: begin
        cmd.out_sel = SEL_REQ0;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = stat.two_pend ? S_REQ1 : S_IDLE;
        end
      end
      S_REQ1: begin
        cmd.out_sel = SEL_REQ1;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_REJ: begin
        cmd.out_sel = SEL_REJ;
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FWR: begin
        cmd.op    = OP_FWR;
        state_nxt = (stat.last_word && stat.last_line) ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.op    = OP_LOADPF;
        fin_nxt   = 1'b1;
        state_nxt = S_T0;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      fin_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fin_r   <= fin_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

@@ sv/sbic_checker.sv @@
// port level checks for the split bank instruction cache
module sbic_checker import sbic_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transfer taken while busy");

  a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.kind != KIND_REQ |-> out_data.last)
    else $error("data or reject result without last");

  a_second_req: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.kind == KIND_REQ && !out_data.last
    |=> out_valid && out_data.kind == KIND_REQ && out_data.last)
    else $error("second refill request missing");

endmodule

bind split_bank_instruction_cache_top sbic_checker u_sbic_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
